// ===== sv/ring_fifo_bulk_peek_defines.svh =====
// Assertion macros for the ring FIFO with bulk read and peek.
`ifndef RING_FIFO_BULK_PEEK_DEFINES_SVH
`define RING_FIFO_BULK_PEEK_DEFINES_SVH

`ifndef SYNTH
`define RFBP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define RFBP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);
`define RFBP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RFBP_ASSERT(lbl, clk, rstn, prop, msg)
`define RFBP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RFBP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== sv/rfbp_pkg.sv =====
`default_nettype none
package rfbp_pkg;

	localparam int DEPTH        = 16;
	localparam int ELEMENT_BITS = 32;
	localparam int MAX_LOG2     = $clog2(DEPTH + 1) - 1;
	localparam int PTR_W        = MAX_LOG2 + 1;
	localparam int ADDR_W       = $clog2(DEPTH);
	localparam int LOG2_W       = 3;
	localparam int OPCODE_W     = 2;
	localparam int CNT_W        = 5;
	localparam int DATA_W       = 32;
	localparam logic [LOG2_W-1:0] LOG2_RESET = LOG2_W'(4);

	typedef enum logic [OPCODE_W-1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_PEEK   = 2'd2,
		OP_STATUS = 2'd3
	} opcode_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [ADDR_W-1:0] raddr;
	} mem_ctl_t;

	typedef struct packed {
		logic             strobe;
		logic             valid;
		logic             last;
		logic             wacc;
		logic [CNT_W-1:0] fill;
		logic [CNT_W-1:0] free;
		logic             full;
		logic             empty;
	} res_t;

endpackage
`default_nettype wire

// ===== sv/rfbp_ram.sv =====
`default_nettype none
module rfbp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/rfbp_ctrl.sv =====
`default_nettype none
`include "ring_fifo_bulk_peek_defines.svh"
module rfbp_ctrl (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [rfbp_pkg::LOG2_W-1:0]     cfg_data,
	input  wire logic                            start,
	input  wire rfbp_pkg::opcode_t               opcode,
	input  wire logic [rfbp_pkg::CNT_W-1:0]      request_count,
	output logic                                 busy,
	output rfbp_pkg::mem_ctl_t                   mem_ctl,
	output rfbp_pkg::res_t                       res
);
	import rfbp_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t             state_q;
	logic [LOG2_W-1:0]  cap_log2_q;
	logic [PTR_W-1:0]   wp_q;
	logic [PTR_W-1:0]   rp_q;
	logic [PTR_W-1:0]   base_q;
	logic [PTR_W-1:0]   idx_q;
	logic [PTR_W-1:0]   n_last_q;
	logic               strobe_q;
	logic               valid_q;
	logic               last_q;
	logic               wacc_q;

	logic [LOG2_W-1:0]  cap_log2_eff;
	logic [PTR_W-1:0]   cap;
	logic [PTR_W-1:0]   cap_mask;
	logic [PTR_W-1:0]   fill;
	logic [PTR_W-1:0]   req_p;
	logic [PTR_W-1:0]   n_take;
	logic               accept;
	logic               wr_ok;

	always_comb begin
		cap_log2_eff = (cap_log2_q > LOG2_W'(MAX_LOG2)) ? LOG2_W'(MAX_LOG2) : cap_log2_q;
		cap          = PTR_W'(1) << cap_log2_eff;
		cap_mask     = cap - PTR_W'(1);
		fill         = wp_q - rp_q;
		req_p        = PTR_W'(request_count);
		n_take       = (req_p > fill) ? fill : req_p;
		busy         = (state_q == S_RUN);
		accept       = start && !busy;
		wr_ok        = fill < cap;
	end

	assign mem_ctl.we    = accept && (opcode == OP_WRITE) && wr_ok;
	assign mem_ctl.waddr = ADDR_W'(wp_q & cap_mask);
	assign mem_ctl.raddr = ADDR_W'((base_q + idx_q) & cap_mask);

	assign res.strobe = strobe_q;
	assign res.valid  = valid_q;
	assign res.last   = last_q;
	assign res.wacc   = wacc_q;
	assign res.fill   = CNT_W'(fill);
	assign res.free   = CNT_W'(cap - fill);
	assign res.full   = (fill == cap);
	assign res.empty  = (fill == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cap_log2_q <= LOG2_RESET;
			wp_q       <= '0;
			rp_q       <= '0;
			base_q     <= '0;
			idx_q      <= '0;
			n_last_q   <= '0;
			strobe_q   <= 1'b0;
			valid_q    <= 1'b0;
			last_q     <= 1'b0;
			wacc_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			valid_q  <= 1'b0;
			last_q   <= 1'b0;
			wacc_q   <= 1'b0;
			if (cfg_we) begin
				cap_log2_q <= cfg_data;
				wp_q       <= '0;
				rp_q       <= '0;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (accept) begin
							unique case (opcode) inside
								OP_WRITE: begin
									strobe_q <= 1'b1;
									last_q   <= 1'b1;
									wacc_q   <= wr_ok;
									if (wr_ok) begin
										wp_q <= wp_q + PTR_W'(1);
									end
								end
								OP_READ, OP_PEEK: begin
									if (n_take == '0) begin
										strobe_q <= 1'b1;
										last_q   <= 1'b1;
									end else begin
										state_q  <= S_RUN;
										base_q   <= rp_q;
										idx_q    <= '0;
										n_last_q <= n_take - PTR_W'(1);
										if (opcode == OP_READ) begin
											rp_q <= rp_q + n_take;
										end
									end
								end
								default: begin
									strobe_q <= 1'b1;
									last_q   <= 1'b1;
								end
							endcase
						end
					end
					S_RUN: begin
						strobe_q <= 1'b1;
						valid_q  <= 1'b1;
						last_q   <= (idx_q == n_last_q);
						idx_q    <= idx_q + PTR_W'(1);
						if (idx_q == n_last_q) begin
							state_q <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	`RFBP_ASSERT(a_fill_in_cap, clk, arst_n, fill <= cap, "fill level exceeds capacity")
	`RFBP_ASSERT_IMP(a_no_write_in_run, clk, arst_n, state_q == S_RUN, !mem_ctl.we, "memory written during a burst")
	`RFBP_ASSERT_NXT(a_ptr_hold_in_run, clk, arst_n, (state_q == S_RUN) && !cfg_we, $stable(wp_q) && $stable(rp_q), "pointers moved during a burst")
	`RFBP_ASSERT_IMP(a_valid_has_strobe, clk, arst_n, valid_q, strobe_q, "data valid without a result beat")
	`RFBP_ASSERT_IMP(a_more_beats_busy, clk, arst_n, strobe_q && !last_q, state_q == S_RUN, "burst ended before its last beat")

endmodule
`default_nettype wire

// ===== sv/ring_fifo_bulk_peek.sv =====
// Write and status requests, and a read or peek that finds nothing, give one result beat
// in the cycle after acceptance; a new request is taken in every cycle while busy is low.
// A read or peek of n elements (n is capped at the fill level) holds busy while it drives
// one read of the element memory per cycle, and its beats carry the memory's read data.
// The receiver cannot stall. Reset clears both pointers and sets capacity_log2 to 4;
// the element memory is not cleared.
`default_nettype none
module ring_fifo_bulk_peek (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [rfbp_pkg::LOG2_W-1:0]     cfg_data,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [rfbp_pkg::OPCODE_W-1:0]   opcode,
	input  wire logic [rfbp_pkg::DATA_W-1:0]     data_in,
	input  wire logic [rfbp_pkg::CNT_W-1:0]      request_count,
	output logic                                 result_strobe,
	output logic      [rfbp_pkg::DATA_W-1:0]     data_out,
	output logic                                 data_valid,
	output logic                                 last,
	output logic                                 write_accepted,
	output logic      [rfbp_pkg::CNT_W-1:0]      fill_count,
	output logic      [rfbp_pkg::CNT_W-1:0]      free_count,
	output logic                                 full_res,
	output logic                                 empty_res
);
	import rfbp_pkg::*;

	mem_ctl_t                mem_ctl;
	res_t                    res;
	logic [ELEMENT_BITS-1:0] rdata;

	rfbp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.start         (start),
		.opcode        (opcode_t'(opcode)),
		.request_count (request_count),
		.busy          (busy),
		.mem_ctl       (mem_ctl),
		.res           (res)
	);

	rfbp_ram #(
		.WIDTH (ELEMENT_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_ctl.we),
		.waddr (mem_ctl.waddr),
		.wdata (ELEMENT_BITS'(data_in)),
		.raddr (mem_ctl.raddr),
		.rdata (rdata)
	);

	assign result_strobe  = res.strobe;
	assign data_valid     = res.valid;
	assign data_out       = res.valid ? DATA_W'(rdata) : '0;
	assign last           = res.last;
	assign write_accepted = res.wacc;
	assign fill_count     = res.fill;
	assign free_count     = res.free;
	assign full_res       = res.full;
	assign empty_res      = res.empty;

endmodule
`default_nettype wire
